>>> rtl/rau_pkg.sv
package rau_pkg;

    // Default numerator width; denominators are one bit narrower.
    localparam int OPERAND_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_PREP,
        ST_GCD,
        ST_DIVN,
        ST_DLOAD,
        ST_DIVD,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_P0,
        MUL_P1,
        MUL_DEN
    } mul_step_t;

    typedef struct packed {
        logic      load;
        mul_step_t mul_step;
        logic      sum;
        logic      prep;
        logic      gcd_step;
        logic      div_load_n;
        logic      div_load_d;
        logic      div_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic den_zero;
        logic gcd_done;
    } status_t;

endpackage

>>> rtl/rau_datapath.sv
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                            clk,
    input  cmd_t                            cmd,
    output status_t                         status,
    input  logic [1:0]                      operation,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-2:0]        a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-2:0]        b_den,
    output logic signed [31:0]              res_num,
    output logic [30:0]                     res_den,
    output logic                            div_by_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = PW;
    localparam int KW = $clog2(MW);
    localparam int EW = (MW > 32) ? MW : 32;

    op_t                 op_reg, op_next;
    logic signed [W-1:0] an_reg, an_next, bn_reg, bn_next;
    logic signed [W-1:0] ad_reg, ad_next, bd_reg, bd_next;
    logic signed [PW-1:0] p0_reg, p0_next, p1_reg, p1_next, den_reg, den_next;
    logic signed [PW:0]  num_reg, num_next;
    logic                neg_reg, neg_next, err_reg, err_next;
    logic [MW-1:0]       nmag_reg, nmag_next, dmag_reg, dmag_next;
    logic [MW-1:0]       x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [MW-1:0]       rem_reg, rem_next, quo_reg, quo_next, qn_reg, qn_next;
    logic signed [31:0]  res_num_reg, res_num_next;
    logic [30:0]         res_den_reg, res_den_next;
    logic                dbz_reg, dbz_next;

    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW:0]   num_abs;
    logic signed [PW-1:0] den_abs;
    logic [MW:0]          trial;
    logic [EW-1:0]        qn_ext, qn_signed, qd_ext;

    // Single shared multiplier, one product per step.
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (cmd.mul_step)
            MUL_P0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            MUL_P1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            MUL_DEN:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign num_abs = num_reg[PW] ? -num_reg : num_reg;
    assign den_abs = den_reg[PW-1] ? -den_reg : den_reg;
    assign trial   = {rem_reg, quo_reg[MW-1]} - {1'b0, g_reg};

    assign qn_ext    = EW'(qn_reg);
    assign qn_signed = neg_reg ? -qn_ext : qn_ext;
    assign qd_ext    = EW'(quo_reg);

    assign status.den_zero = (den_reg == '0);
    assign status.gcd_done = (x_reg == '0) || (y_reg == '0);

    always_comb
    begin
        op_next      = op_reg;
        an_next      = an_reg;
        bn_next      = bn_reg;
        ad_next      = ad_reg;
        bd_next      = bd_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        neg_next     = neg_reg;
        err_next     = err_reg;
        nmag_next    = nmag_reg;
        dmag_next    = dmag_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        g_next       = g_reg;
        k_next       = k_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        qn_next      = qn_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        dbz_next     = dbz_reg;

        if (cmd.load)
        begin
            op_next  = op_t'(operation);
            an_next  = a_num;
            bn_next  = b_num;
            ad_next  = $signed({1'b0, a_den});
            bd_next  = $signed({1'b0, b_den});
            err_next = 1'b0;
        end

        case (cmd.mul_step)
            MUL_P0:  p0_next  = prod;
            MUL_P1:  p1_next  = prod;
            MUL_DEN: den_next = prod;
            default: ;
        endcase

        if (cmd.sum)
        begin
            case (op_reg)
                OP_ADD:  num_next = (PW+1)'(p0_reg) + (PW+1)'(p1_reg);
                OP_SUB:  num_next = (PW+1)'(p0_reg) - (PW+1)'(p1_reg);
                default: num_next = (PW+1)'(p0_reg);
            endcase
        end

        if (cmd.prep)
        begin
            neg_next  = num_reg[PW] ^ den_reg[PW-1];
            nmag_next = num_abs[MW-1:0];
            dmag_next = den_abs[MW-1:0];
            x_next    = den_abs[MW-1:0];
            y_next    = num_abs[MW-1:0];
            k_next    = '0;
            err_next  = (den_reg == '0);
        end

        // Binary gcd: common factors of two are counted in k and restored below.
        if (cmd.gcd_step && !status.gcd_done)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = (x_reg - y_reg) >> 1;
            end
            else
            begin
                y_next = (y_reg - x_reg) >> 1;
            end
        end

        if (cmd.div_load_n)
        begin
            g_next   = (x_reg | y_reg) << k_reg;
            rem_next = '0;
            quo_next = nmag_reg;
        end

        if (cmd.div_load_d)
        begin
            qn_next  = quo_reg;
            rem_next = '0;
            quo_next = dmag_reg;
        end

        // Restoring division, one quotient bit per step.
        if (cmd.div_step)
        begin
            if (!trial[MW])
            begin
                rem_next = trial[MW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[MW-2:0], quo_reg[MW-1]};
                quo_next = {quo_reg[MW-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            res_num_next = err_reg ? '0 : $signed(qn_signed[31:0]);
            res_den_next = err_reg ? '0 : qd_ext[30:0];
            dbz_next     = err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        an_reg      <= an_next;
        bn_reg      <= bn_next;
        ad_reg      <= ad_next;
        bd_reg      <= bd_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        neg_reg     <= neg_next;
        err_reg     <= err_next;
        nmag_reg    <= nmag_next;
        dmag_reg    <= dmag_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        g_reg       <= g_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        qn_reg      <= qn_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        dbz_reg     <= dbz_next;
    end

    assign res_num     = res_num_reg;
    assign res_den     = res_den_reg;
    assign div_by_zero = dbz_reg;

endmodule

>>> rtl/rau_ctrl.sv
module rau_ctrl
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(MW);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_PREP;
            ST_PREP:   state_next = status.den_zero ? ST_FINISH : ST_GCD;
            ST_GCD:
            begin
                if (status.gcd_done)
                begin
                    state_next = ST_DIVN;
                    cnt_next   = CW'(MW - 1);
                end
            end
            ST_DIVN:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DLOAD;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            ST_DLOAD:
            begin
                state_next = ST_DIVD;
                cnt_next   = CW'(MW - 1);
            end
            ST_DIVD:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mul_step = MUL_NONE;
        unique case (state_reg)
            ST_IDLE:   cmd.load       = in_valid;
            ST_MUL0:   cmd.mul_step   = MUL_P0;
            ST_MUL1:   cmd.mul_step   = MUL_P1;
            ST_MUL2:   cmd.mul_step   = MUL_DEN;
            ST_SUM:    cmd.sum        = 1'b1;
            ST_PREP:   cmd.prep       = 1'b1;
            ST_GCD:
            begin
                cmd.gcd_step   = 1'b1;
                cmd.div_load_n = status.gcd_done;
            end
            ST_DIVN:   cmd.div_step   = 1'b1;
            ST_DLOAD:  cmd.div_load_d = 1'b1;
            ST_DIVD:   cmd.div_step   = 1'b1;
            ST_FINISH: cmd.out_load   = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/rational_arithmetic_unit.sv
// The block takes one item at a time: in_stall is high from the input transfer until the
// controller returns to idle, and a zero denominator skips the gcd and both divisions.
// It waits in its final state while a finished result is held by a stalled output register.
// The two bit-serial divisions through the shared divider and the gcd loop set how long an item takes.
// Reset (rst_n, asynchronous, active low) idles the controller and empties the output.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-2:0]        a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-2:0]        b_den,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              res_num,
    output logic [30:0]                     res_den,
    output logic                            div_by_zero
);

    // The controller steps the datapath through three products on one shared
    // multiplier, the sum, sign and magnitude split, a binary gcd, and two
    // restoring divisions by the gcd. The result sits in an output register,
    // so a new input transfer can start while the last result is still unread.
    cmd_t    cmd;
    status_t status;

    rau_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rau_datapath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .operation  (operation),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .res_num    (res_num),
        .res_den    (res_den),
        .div_by_zero(div_by_zero)
    );

    // Once an input transfer is taken, the block is busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took an item but did not become busy");

    // An error result always carries zeroed fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> res_num == 32'sd0 && res_den == 31'd0)
        else $error("error result with nonzero fields");

    // A fresh result is loaded only as the controller returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while the controller was still busy");

endmodule

>>> tb/tb_rational_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    // Numerators are signed at the default operand width, and denominators are one bit narrower.
    localparam int NUM_W = OPERAND_WIDTH_DEF;
    localparam int DEN_W = OPERAND_WIDTH_DEF - 1;
    localparam int MIN_NUM = -(2 ** (NUM_W - 1));
    localparam int MAX_NUM = 2 ** (NUM_W - 1) - 1;
    localparam int MAX_DEN = 2 ** DEN_W - 1;

    // The drain wait is set well beyond the longest time that one item can take. The watchdog
    // allows for about 1550 items, each with its longest sender gap, stalls and the long output
    // hold-off, several times over.
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int LIMIT_CYCLES = 2000000;

    // One reduced fraction, as the block should return it.
    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               dbz;
    } fraction_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              operation = OP_ADD;
    logic signed [NUM_W-1:0] a_num = '0;
    logic [DEN_W-1:0]        a_den = 1;
    logic signed [NUM_W-1:0] b_num = '0;
    logic [DEN_W-1:0]        b_den = 1;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [31:0]      res_num;
    logic [30:0]             res_den;
    logic                    div_by_zero;

    // Fractions that the block still owes, oldest first.
    fraction_t expected_fractions[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // Idling odds in percent, per item sent and per cycle. Each test sets them for its own phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The long output hold-off runs in a process of its own, which the output hold-off test starts.
    event hold_go;
    logic holding = 1'b0;
    int   hold_count;

    rational_arithmetic_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .a_num       (a_num),
        .a_den       (a_den),
        .b_num       (b_num),
        .b_den       (b_den),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res_num     (res_num),
        .res_den     (res_den),
        .div_by_zero (div_by_zero)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // This function forms the cross products for the operation and reduces them by their
    // greatest common divisor. The sign is moved onto the numerator. A zero product
    // denominator gives the error result, with both fields at zero.
    function automatic fraction_t reduce_rational(input op_t op,
                                                  input logic signed [NUM_W-1:0] an,
                                                  input logic [DEN_W-1:0] ad,
                                                  input logic signed [NUM_W-1:0] bn,
                                                  input logic [DEN_W-1:0] bd);
        longint    san, sad, sbn, sbd;
        longint    num, den, nmag, dmag, x, y, r;
        logic      neg;
        fraction_t res;

        san = an;
        sad = ad;
        sbn = bn;
        sbd = bd;
        case (op)
            OP_ADD:
            begin
                num = san * sbd + sbn * sad;
                den = sad * sbd;
            end
            OP_SUB:
            begin
                num = san * sbd - sbn * sad;
                den = sad * sbd;
            end
            OP_MUL:
            begin
                num = san * sbn;
                den = sad * sbd;
            end
            default:
            begin
                num = san * sbd;
                den = sad * sbn;
            end
        endcase

        if (den == 0)
        begin
            res.num = '0;
            res.den = '0;
            res.dbz = 1'b1;
            return res;
        end

        neg  = (num < 0) ^ (den < 0);
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;

        // Euclid's method. A zero numerator leaves the divisor at the denominator, so the
        // result becomes 0/1.
        x = dmag;
        y = nmag;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end

        nmag = nmag / x;
        dmag = dmag / x;
        if (neg)
            nmag = -nmag;
        res.num = nmag[31:0];
        res.den = dmag[30:0];
        res.dbz = 1'b0;
        return res;
    endfunction

    // This task offers one item and returns at the clock edge of its transfer. in_valid
    // stays high on return, so that the next call can keep it up or drop it for a gap.
    task automatic send_item(input op_t op,
                             input logic signed [NUM_W-1:0] an,
                             input logic [DEN_W-1:0] ad,
                             input logic signed [NUM_W-1:0] bn,
                             input logic [DEN_W-1:0] bd);
        int gap;

        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            // Most gaps are short. Now and then a long gap lets the block run empty.
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 4);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end

        in_valid  <= 1'b1;
        operation <= op;
        a_num     <= an;
        a_den     <= ad;
        b_num     <= bn;
        b_den     <= bd;
        do
            @(posedge clk);
        while (in_stall);
        expected_fractions.push_back(reduce_rational(op, an, ad, bn, bd));
    endtask

    // Numerators favor the extremes and small values, so that sums cancel and fractions
    // reduce. The rest are drawn from the full range.
    function automatic logic signed [NUM_W-1:0] rand_numerator();
        int v;

        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = MIN_NUM;
                    1:       v = MAX_NUM;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = int'($urandom_range(0, 128)) - 64;
            default: v = $urandom;
        endcase
        return v[NUM_W-1:0];
    endfunction

    // Denominators are out of range at zero now and then. Otherwise they are small,
    // powers of two, the maximum, or drawn from the full range.
    function automatic logic [DEN_W-1:0] rand_denominator();
        int v;

        case ($urandom_range(0, 39))
            0:             v = 0;
            1, 2:          v = MAX_DEN;
            3, 4, 5, 6, 7,
            8, 9, 10, 11, 12:
                           v = $urandom_range(1, 64);
            13, 14, 15, 16:
                           v = 1 << $urandom_range(0, DEN_W - 1);
            default:       v = $urandom_range(1, MAX_DEN);
        endcase
        return v[DEN_W-1:0];
    endfunction

    task automatic send_random_items(input int count);
        op_t                     op;
        logic signed [NUM_W-1:0] an, bn;
        logic [DEN_W-1:0]        ad, bd;

        repeat (count)
        begin
            op = op_t'($urandom_range(0, 3));
            an = rand_numerator();
            ad = rand_denominator();
            bn = rand_numerator();
            bd = rand_denominator();
            // Division by a zero fraction gets extra weight.
            if (op == OP_DIV && $urandom_range(0, 9) == 0)
                bn = '0;
            send_item(op, an, ad, bn, bd);
        end
    endtask

    // Directed items cover every operation, the extremes of the fields, a zero result,
    // a sign moved off the denominator, division by a zero fraction and zero input
    // denominators.
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(OP_ADD, 1, 2, 1, 3);
        send_item(OP_SUB, 1, 2, 1, 2);
        send_item(OP_MUL, 2, 4, 3, 9);
        send_item(OP_DIV, 1, 2, -1, 3);
        send_item(OP_DIV, 3, 4, 0, 5);
        send_item(OP_ADD, 5, 0, 7, 3);
        send_item(OP_MUL, 5, 3, 7, 0);
        send_item(OP_DIV, 5, 0, 7, 3);
        send_item(OP_SUB, 0, 0, 0, 0);
        send_item(OP_ADD, MAX_NUM, 1, MAX_NUM, 1);
        send_item(OP_ADD, MIN_NUM, 1, MIN_NUM, 1);
        send_item(OP_SUB, MIN_NUM, MAX_DEN, MAX_NUM, 1);
        send_item(OP_MUL, MIN_NUM, 1, MIN_NUM, 1);
        send_item(OP_MUL, MAX_NUM, MAX_DEN, MAX_NUM, MAX_DEN);
        send_item(OP_DIV, MIN_NUM, 1, -1, MAX_DEN);
        send_item(OP_DIV, -1, MAX_DEN, MIN_NUM, MAX_DEN);
        send_item(OP_DIV, MAX_NUM, 1, MIN_NUM, 1);
        send_item(OP_ADD, 0, 1, 0, MAX_DEN);
        send_item(OP_MUL, 0, 5, -7, 3);
        send_item(OP_DIV, 0, 3, 5, 7);
        send_item(OP_SUB, -1, 1, -1, 1);
        send_item(OP_ADD, -1, MAX_DEN, -1, MAX_DEN);
    endtask

    task automatic test_streaming_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_items(380);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 47;
        recv_stall_pct = 0;
        send_random_items(380);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        send_random_items(380);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        send_random_items(380);
    endtask

    // The receiver holds off much longer than one item takes, while the sender keeps
    // offering. The held result fills the block, and its input must stall until the
    // hold-off ends.
    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        send_random_items(8);
    endtask

    always
    begin
        @(hold_go);
        holding <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
            @(posedge clk);
        holding <= 1'b0;
    end

    // The receiver samples the handshake at each rising edge, so that it sees the values
    // from before the edge. On a transfer it checks the result against the oldest
    // expected fraction. Then it chooses the stall for the next cycle.
    always @(posedge clk)
    begin : result_check
        fraction_t want;

        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_fractions.size() == 0)
                begin
                    $display("%0t: unexpected result %0d/%0d div_by_zero %0b", $time,
                             res_num, res_den, div_by_zero);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_fractions.pop_front();
                    if (res_num !== want.num)
                    begin
                        $display("%0t: res_num expected %0d, actual %0d", $time,
                                 want.num, res_num);
                        mismatch_count++;
                    end
                    if (res_den !== want.den)
                    begin
                        $display("%0t: res_den expected %0d, actual %0d", $time,
                                 want.den, res_den);
                        mismatch_count++;
                    end
                    if (div_by_zero !== want.dbz)
                    begin
                        $display("%0t: div_by_zero expected %0b, actual %0b", $time,
                                 want.dbz, div_by_zero);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= holding ||
                         (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // The watchdog ends a run that hangs.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_streaming_no_idle();
        test_output_hold_off();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        in_valid <= 1'b0;

        // The run waits for every owed result, and then for a while longer so that a
        // stray extra result would still be seen.
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> rational_arithmetic_unit.f
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
tb/tb_rational_arithmetic_unit.sv
